// File: hw/rtl/liu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// liu_pkg
// Shared types and constants for the linear interpolation upsampler.
// ----------------------------------------------------------------------------
package liu_pkg;

  localparam int unsigned MAX_FACTOR_DEF   = 64;
  localparam int unsigned SAMPLE_WIDTH_DEF = 16;
  localparam int unsigned FACTOR_WIDTH     = 7;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_DIV    = 4'b0010,
    ST_INTERP = 4'b0100,
    ST_ORIG   = 4'b1000
  } seq_state_e;

endpackage

// File: hw/rtl/linear_interpolation_upsampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_interpolation_upsampler
// Raises the sample rate by the configured factor with linear interpolation.
// ----------------------------------------------------------------------------
// One sample is taken at a time. The first sample of a set, and every
// sample when the factor is zero or one, gives a single beat, the sample.
// Every other sample first runs a serial division of |cur - prev| by
// the factor (one quotient bit per cycle), then emits factor-1
// interpolated beats and the sample itself at one beat per cycle while
// the output is not stalled, from a running quotient and remainder. The
// input is stalled until the sample's own beat has been loaded into the
// output register. The factor register must only be written while the
// block is idle.
module linear_interpolation_upsampler
  import liu_pkg::*;
#(
  parameter int unsigned MAX_FACTOR   = MAX_FACTOR_DEF,
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [FACTOR_WIDTH-1:0]        cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  logic                           last_of_set_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [SAMPLE_WIDTH-1:0] value_o,
  output logic                           is_original_o,
  output logic                           last_of_run_o
);

  localparam int unsigned W  = SAMPLE_WIDTH;
  localparam int unsigned FW = FACTOR_WIDTH;

  seq_state_e    state_q, state_d;
  logic [FW-1:0] factor_q;
  logic [FW-1:0] f_clamp;
  logic [W-1:0]  prev_q, prev_d;
  logic          have_q, have_d;
  logic [W-1:0]  cur_q, cur_d;
  logic          last_q, last_d;
  logic [FW-1:0] f_q, f_d;
  logic          neg_q, neg_d;
  logic [FW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  a_q, a_d;
  logic [FW-1:0] b_q, b_d;
  logic [W-1:0]  acc_q, acc_d;
  logic [FW-1:0] r_q, r_d;

  logic          out_valid_q, out_valid_d;
  logic [W-1:0]  value_q, value_d;
  logic          orig_q, orig_d;
  logic          lrun_q, lrun_d;

  logic          accept;
  logic          load_ok;
  logic          div_start;
  logic          div_done;
  logic [W-1:0]  div_quot;
  logic [FW-1:0] div_rem;
  logic [W:0]    diff;
  logic [W-1:0]  mag;
  logic [FW:0]   r_sum;
  logic          wrap;
  logic [FW-1:0] r_nxt;
  logic [W-1:0]  acc_nxt;
  logic [W:0]    step_s;
  logic [W-1:0]  interp;

  always_comb begin
    if (factor_q == '0) begin
      f_clamp = FW'(1);
    end else if (factor_q > FW'(MAX_FACTOR)) begin
      f_clamp = FW'(MAX_FACTOR);
    end else begin
      f_clamp = factor_q;
    end
  end

  assign accept  = in_valid_i && (state_q == ST_IDLE);
  assign load_ok = !out_valid_q || !out_stall_i;

  assign diff = {sample_i[W-1], sample_i} - {prev_q[W-1], prev_q};
  assign mag  = diff[W] ? W'(-diff) : W'(diff);

  assign div_start = accept && have_q && (f_clamp != FW'(1));

  liu_div #(
    .DW(W),
    .VW(FW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(mag),
    .divisor_i (f_clamp),
    .done_o    (div_done),
    .quot_o    (div_quot),
    .rem_o     (div_rem)
  );

  // running quotient and remainder of k * |diff| / factor
  assign r_sum   = {1'b0, r_q} + {1'b0, b_q};
  assign wrap    = r_sum >= {1'b0, f_q};
  assign r_nxt   = wrap ? FW'(r_sum - {1'b0, f_q}) : FW'(r_sum);
  assign acc_nxt = W'({1'b0, acc_q} + {1'b0, a_q} + (W+1)'(wrap));
  assign step_s  = neg_q ? (W+1)'(-{1'b0, acc_nxt}) : {1'b0, acc_nxt};
  assign interp  = W'({prev_q[W-1], prev_q} + step_s);

  always_comb begin
    state_d     = state_q;
    prev_d      = prev_q;
    have_d      = have_q;
    cur_d       = cur_q;
    last_d      = last_q;
    f_d         = f_q;
    neg_d       = neg_q;
    cnt_d       = cnt_q;
    a_d         = a_q;
    b_d         = b_q;
    acc_d       = acc_q;
    r_d         = r_q;
    value_d     = value_q;
    orig_d      = orig_q;
    lrun_d      = lrun_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cur_d   = sample_i;
          last_d  = last_of_set_i;
          f_d     = f_clamp;
          neg_d   = diff[W];
          cnt_d   = f_clamp - FW'(1);
          acc_d   = '0;
          r_d     = '0;
          state_d = div_start ? ST_DIV : ST_ORIG;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          a_d     = div_quot;
          b_d     = div_rem;
          state_d = ST_INTERP;
        end
      end
      ST_INTERP: begin
        if (load_ok) begin
          value_d     = interp;
          orig_d      = 1'b0;
          lrun_d      = 1'b0;
          out_valid_d = 1'b1;
          acc_d       = acc_nxt;
          r_d         = r_nxt;
          cnt_d       = cnt_q - FW'(1);
          if (cnt_q == FW'(1)) begin
            state_d = ST_ORIG;
          end
        end
      end
      ST_ORIG: begin
        if (load_ok) begin
          value_d     = cur_q;
          orig_d      = 1'b1;
          lrun_d      = 1'b1;
          out_valid_d = 1'b1;
          prev_d      = cur_q;
          have_d      = !last_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      factor_q    <= FW'(1);
      prev_q      <= '0;
      have_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      prev_q      <= prev_d;
      have_q      <= have_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        factor_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    last_q  <= last_d;
    f_q     <= f_d;
    neg_q   <= neg_d;
    a_q     <= a_d;
    b_q     <= b_d;
    acc_q   <= acc_d;
    r_q     <= r_d;
    value_q <= value_d;
    orig_q  <= orig_d;
    lrun_q  <= lrun_d;
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign value_o       = value_q;
  assign is_original_o = orig_q;
  assign last_of_run_o = lrun_q;

`ifndef ASSERT_OFF
  a_last_is_orig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (last_of_run_o || is_original_o)) |-> (last_of_run_o && is_original_o))
    else $error("last beat and original flag disagree");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken again right after a beat");

  a_interp_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INTERP) |-> (cnt_q != '0))
    else $error("interpolation count ran out");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("division finished outside of division state");
`endif

endmodule

// File: hw/rtl/liu_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// liu_div
// Serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module liu_div #(
  parameter int unsigned DW = 16,
  parameter int unsigned VW = 7
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quot_o,
  output logic [VW-1:0] rem_o
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] quot_q, quot_d;
  logic [VW-1:0] rem_q, rem_d;
  logic [VW-1:0] dvs_q, dvs_d;
  logic [VW:0]   trial;
  logic          ge;

  assign trial = {rem_q, quot_q[DW-1]};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(DW);
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quot_d = {quot_q[DW-2:0], ge};
      rem_d  = ge ? VW'(trial - {1'b0, dvs_q}) : VW'(trial);
      cnt_d  = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule
